// ----- hdl/hkd_pkg.sv -----
// ----------------------------------------------------------------------------
// HSV key frame detector package
// Shared widths, constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package hkd_pkg;

  // Pixel limit per frame and fractional bits of the HSV terms.
  localparam int MAX_PIXELS = 65536;
  localparam int FRAC_BITS  = 8;

  localparam int PIX_W  = 8;                // one color component
  localparam int FEAT_W = 12;               // frame feature and change
  localparam int Q_W    = FRAC_BITS + 8;    // quotient bits of the pixel divider
  localparam int HUE_W  = FRAC_BITS + 9;    // hue up to 360 in fixed point
  localparam int SV_W   = FRAC_BITS + 1;    // saturation and value up to 1.0
  localparam int TERM_W = FRAC_BITS + FEAT_W;
  localparam int CNT_W  = $clog2(MAX_PIXELS + 1);
  localparam int SUM_W  = TERM_W + $clog2(MAX_PIXELS);
  localparam int FDIV_W = CNT_W + FRAC_BITS;
  localparam int STEP_W = $clog2(Q_W);

  // 2^FRAC_BITS = 255 * VAL_Q + VAL_R, so that the value term needs no divider.
  localparam int VAL_Q = (1 << FRAC_BITS) / 255;
  localparam int VAL_R = (1 << FRAC_BITS) % 255;

  localparam logic [HUE_W-1:0]  HUE_FULL = HUE_W'(360) << FRAC_BITS;
  localparam logic [SV_W-1:0]   SV_ONE   = SV_W'(1) << FRAC_BITS;
  localparam logic [PIX_W-1:0]  PIX_MAX  = PIX_W'(255);
  localparam logic [CNT_W-1:0]  CNT_MAX  = CNT_W'(MAX_PIXELS);
  localparam logic [FEAT_W-1:0] THRESH_RESET = FEAT_W'(14);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_pixel;   // capture the pixel and set up the divider lanes
    logic pix_step;     // one restoring step in all pixel divider lanes
    logic calc_term;    // register 9h + 3s + v
    logic accumulate;   // add the term to the frame sum
    logic load_frame;   // set up the frame mean divider
    logic frame_step;   // one restoring step of the frame divider
    logic finish;       // publish the result and close the frame
  } hkd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pix_last;     // the captured pixel ends its frame
    logic out_busy;     // the output register holds an untaken result
  } hkd_sts_t;

endpackage

// ----- hdl/hkd_ctrl.sv -----
// ----------------------------------------------------------------------------
// HSV key frame detector controller
// Sequences pixel capture, the division steps, accumulation and frame close.
// ----------------------------------------------------------------------------
module hkd_ctrl
  import hkd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  hkd_sts_t sts,
  output hkd_cmd_t cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PDIV  = 3'd1;
  localparam logic [2:0] S_TERM  = 3'd2;
  localparam logic [2:0] S_ACC   = 3'd3;
  localparam logic [2:0] S_FLOAD = 3'd4;
  localparam logic [2:0] S_FDIV  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]        state, state_next;
  logic [STEP_W-1:0] step, step_next;

  // No pixel is taken while reset is applied.
  assign s_tready = (state == S_IDLE) && !rst;

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load_pixel = 1'b1;
          step_next      = STEP_W'(Q_W - 1);
          state_next     = S_PDIV;
        end
      end
      S_PDIV: begin
        cmd.pix_step = 1'b1;
        if (step == '0) begin
          state_next = S_TERM;
        end else begin
          step_next = step - 1'b1;
        end
      end
      S_TERM: begin
        cmd.calc_term = 1'b1;
        state_next    = S_ACC;
      end
      S_ACC: begin
        cmd.accumulate = 1'b1;
        state_next     = sts.pix_last ? S_FLOAD : S_IDLE;
      end
      S_FLOAD: begin
        cmd.load_frame = 1'b1;
        step_next      = STEP_W'(FEAT_W - 1);
        state_next     = S_FDIV;
      end
      S_FDIV: begin
        cmd.frame_step = 1'b1;
        if (step == '0) begin
          state_next = S_DONE;
        end else begin
          step_next = step - 1'b1;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

endmodule

// ----- hdl/hkd_dp.sv -----
// ----------------------------------------------------------------------------
// HSV key frame detector datapath
// Pixel divider lanes, term and frame sum, frame mean divider, result register.
// ----------------------------------------------------------------------------
module hkd_dp
  import hkd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [23:0]           s_tdata,
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,
  output logic                  m_tuser,
  input  logic                  change_threshold_we,
  input  logic [FEAT_W-1:0]     change_threshold_data,
  input  hkd_cmd_t              cmd,
  output hkd_sts_t              sts
);

  localparam int LANES = 2;   // hue, saturation

  // Pixel decode.
  logic [PIX_W-1:0] blue, green, red, mx, mn, dif;
  logic [9:0]       nsum;
  logic [15:0]      n60;
  logic [PIX_W+Q_W-1:0] hue_dvd;
  logic [15:0]      vprod;
  logic [24:0]      vrecip;
  logic [SV_W-1:0]  val_next;

  // Pixel divider lanes.
  logic [PIX_W-1:0] rem [LANES], rem_next [LANES], dvs [LANES];
  logic [Q_W-1:0]   shq [LANES], shq_next [LANES];
  logic             flat, g_ge_b, last;

  // Term and frame accumulation.
  logic [HUE_W-1:0]  hue;
  logic [SV_W-1:0]   sat, val;
  logic [TERM_W-1:0] term, term_next;
  logic [SUM_W-1:0]  weighted_sum;
  logic [CNT_W-1:0]  pixel_count;

  // Frame mean divider.
  logic [FDIV_W-1:0] frem, fdvs;
  logic [FDIV_W:0]   ftry;
  logic              fge;
  logic [FEAT_W-1:0] fsh;

  // Result and frame history.
  logic [FEAT_W-1:0] change_threshold, previous_feature, change;
  logic              have_previous, key;
  logic [FEAT_W-1:0] out_feature, out_change;
  logic              out_key;

  always_comb begin
    blue  = s_tdata[7:0];
    green = s_tdata[15:8];
    red   = s_tdata[23:16];
    mx = (red > blue) ? red : blue;
    mn = (red > blue) ? blue : red;
    if (green > mx) mx = green;
    if (green < mn) mn = green;
    dif     = mx - mn;
    nsum    = 10'(mx - red) + 10'(green - mn) + 10'(blue - mn);
    n60     = 16'(nsum) * 16'd60;
    hue_dvd = {n60, {FRAC_BITS{1'b0}}};
    // Value is mx * VAL_Q plus floor(mx * VAL_R / 255); the last quotient
    // is exact as (y + 1) * 257 / 2^16 for the small products seen here.
    vprod    = 16'(mx) * 16'(VAL_R);
    vrecip   = 25'(vprod + 17'd1) * 25'd257;
    val_next = SV_W'(mx) * SV_W'(VAL_Q) + SV_W'(vrecip[24:16]);
  end

  // One restoring division step per lane.
  always_comb begin
    logic [PIX_W:0] t;
    logic           ge;
    for (int i = 0; i < LANES; i++) begin
      t  = {rem[i], shq[i][Q_W-1]};
      ge = (t >= {1'b0, dvs[i]});
      rem_next[i] = ge ? PIX_W'(t - {1'b0, dvs[i]}) : t[PIX_W-1:0];
      shq_next[i] = {shq[i][Q_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_pixel) begin
      rem[0] <= hue_dvd[PIX_W+Q_W-1:Q_W];
      shq[0] <= hue_dvd[Q_W-1:0];
      dvs[0] <= dif;
      rem[1] <= '0;
      shq[1] <= {mn, {FRAC_BITS{1'b0}}};
      dvs[1] <= mx;
      val    <= val_next;
      flat   <= (mx == mn);
      g_ge_b <= (green >= blue);
      last   <= s_tlast;
    end else if (cmd.pix_step) begin
      for (int i = 0; i < LANES; i++) begin
        rem[i] <= rem_next[i];
        shq[i] <= shq_next[i];
      end
    end
  end

  always_comb begin
    if (flat) begin
      hue = '0;
      sat = '0;
    end else begin
      hue = g_ge_b ? HUE_W'(shq[0]) : HUE_FULL - HUE_W'(shq[0]);
      sat = SV_ONE - SV_W'(shq[1]);
    end
    term_next = (TERM_W'(hue) << 3) + TERM_W'(hue)
              + (TERM_W'(sat) << 1) + TERM_W'(sat) + TERM_W'(val);
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_term) begin
      term <= term_next;
    end
  end

  always_comb begin
    ftry = {frem, fsh[FEAT_W-1]};
    fge  = (ftry >= {1'b0, fdvs});
  end

  always_ff @(posedge clk) begin
    if (cmd.load_frame) begin
      frem <= FDIV_W'(weighted_sum[SUM_W-1:FEAT_W]);
      fsh  <= weighted_sum[FEAT_W-1:0];
      fdvs <= {pixel_count, {FRAC_BITS{1'b0}}};
    end else if (cmd.frame_step) begin
      frem <= fge ? FDIV_W'(ftry - {1'b0, fdvs}) : ftry[FDIV_W-1:0];
      fsh  <= {fsh[FEAT_W-2:0], fge};
    end
  end

  always_comb begin
    if (!have_previous) begin
      change = '0;
      key    = 1'b1;
    end else begin
      change = (fsh > previous_feature) ? fsh - previous_feature
                                        : previous_feature - fsh;
      key    = (change > change_threshold);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weighted_sum     <= '0;
      pixel_count      <= '0;
      previous_feature <= '0;
      have_previous    <= 1'b0;
      change_threshold <= THRESH_RESET;
      m_tvalid         <= 1'b0;
    end else begin
      if (change_threshold_we) begin
        change_threshold <= change_threshold_data;
      end
      if (cmd.accumulate && (pixel_count < CNT_MAX)) begin
        weighted_sum <= weighted_sum + SUM_W'(term);
        pixel_count  <= pixel_count + 1'b1;
      end
      if (cmd.finish) begin
        weighted_sum     <= '0;
        pixel_count      <= '0;
        previous_feature <= fsh;
        have_previous    <= 1'b1;
        m_tvalid         <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_feature <= fsh;
      out_change  <= change;
      out_key     <= key;
    end
  end

  assign m_tdata      = {out_change, out_feature};
  assign m_tuser      = out_key;
  assign sts.pix_last = last;
  assign sts.out_busy = m_tvalid & ~m_tready;

endmodule

// ----- hdl/hsv_keyframe_detector.sv -----
// ----------------------------------------------------------------------------
// HSV key frame detector
// Mean HSV feature per frame and key frame decision from its change.
// ----------------------------------------------------------------------------
// Pixels enter one per transaction on the slave stream, with s_tlast on the
// last pixel of a frame. Each pixel is converted to hue, saturation and value
// in fixed point and 9h + 3s + v is added to a frame sum; at most MAX_PIXELS
// pixels of a frame are counted, later ones are ignored until the frame ends.
// The pixel that ends a frame produces one result transaction: the truncated
// mean feature, its absolute change from the previous frame (zero for the
// first frame) and a key flag that is set for the first frame or when the
// change is strictly above change_threshold. Each pixel passes through the
// two-lane restoring divider that finds hue and saturation one quotient bit
// per cycle; value comes from a constant reciprocal while the pixel is taken.
// A frame-ending pixel then goes through the bit-serial division of the
// frame sum by the pixel count and waits while the output register still
// holds an untaken previous result. No new pixel is accepted before the
// last one is through, and none during reset. The threshold register
// resets to 14 and should be written only while the block is idle.
module hsv_keyframe_detector
  import hkd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // Pixel stream. s_tdata: blue [7:0], green [15:8], red [23:16].
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [23:0]       s_tdata,
  input  logic              s_tlast,   // last pixel of the frame
  // Result stream. m_tdata: frame_feature [11:0], feature_change [23:12].
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [23:0]       m_tdata,
  output logic              m_tuser,   // is_key
  // Threshold register write.
  input  logic              change_threshold_we,
  input  logic [FEAT_W-1:0] change_threshold_data
);

  hkd_cmd_t cmd;
  hkd_sts_t sts;

  // The controller only sequences with its state and step counter; all other arithmetic and state live in the datapath.
  hkd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hkd_dp u_dp (
    .clk                   (clk),
    .rst                   (rst),
    .s_tdata               (s_tdata),
    .s_tlast               (s_tlast),
    .m_tvalid              (m_tvalid),
    .m_tready              (m_tready),
    .m_tdata               (m_tdata),
    .m_tuser               (m_tuser),
    .change_threshold_we   (change_threshold_we),
    .change_threshold_data (change_threshold_data),
    .cmd                   (cmd),
    .sts                   (sts)
  );

endmodule

// ----- bench/tb_hsv_keyframe_detector.sv -----
// ----------------------------------------------------------------------------
// HSV key frame detector testbench
// Streams pixel frames into the detector and checks every frame result
// against a cycle-free prediction of the mean HSV feature and key decision.
// ----------------------------------------------------------------------------
// The run starts with a few hand-picked frames: black, white, the primaries,
// a frame that mixes the hue branches with gray pixels, and the same frame
// twice, so that the change is zero. After that come phases of random
// frames, each under its own threshold. Some frames repeat the previous
// frame, exactly or with one bit flipped, so that the feature change also
// takes small values near the threshold. The sender works in bursts with
// random gaps. The receiver stalls on a rotating random pattern. Both sides
// run without any idling in some phases.
// ----------------------------------------------------------------------------
module tb_hsv_keyframe_detector;
  import hkd_pkg::*;

  // Cycles to let pass once the last result is in. This covers a pixel still
  // in the pixel divider plus the frame division of a frame end.
  localparam int IDLE_TAIL = 64;

  typedef struct packed {
    logic [FEAT_W-1:0] feature;
    logic              key;
    logic [FEAT_W-1:0] change;
  } frame_result_t;

  // Predicts the result of each frame from the accepted pixels and holds
  // the results that have not come out yet.
  class keyframe_scoreboard;
    logic [63:0]       frame_sum;
    int unsigned       frame_pixels;
    logic [FEAT_W-1:0] last_feature;
    bit                seen_frame;
    logic [FEAT_W-1:0] threshold;
    frame_result_t     pending_frames[$];
    int unsigned       mismatches;

    function new();
      frame_sum    = 0;
      frame_pixels = 0;
      last_feature = '0;
      seen_frame   = 1'b0;
      threshold    = THRESH_RESET;
      mismatches   = 0;
    endfunction

    function void set_threshold(logic [FEAT_W-1:0] value);
      threshold = value;
    endfunction

    // Fixed-point 9h + 3s + v of one pixel, with every division truncated.
    function logic [63:0] hsv_term(logic [23:0] pixel);
      logic [63:0] b, g, r, mx, mn, n, q, h, s, v;
      b = 64'(pixel[7:0]);
      g = 64'(pixel[15:8]);
      r = 64'(pixel[23:16]);
      mx = (r > b) ? r : b;
      mn = (r > b) ? b : r;
      if (g > mx) mx = g;
      if (g < mn) mn = g;
      v = (mx << FRAC_BITS) / 255;
      h = 0;
      s = 0;
      if (mx != mn) begin
        n = (mx - r) + (g - mn) + (b - mn);
        q = ((n * 60) << FRAC_BITS) / (mx - mn);
        h = (g >= b) ? q : ((64'd360 << FRAC_BITS) - q);
        s = (64'd1 << FRAC_BITS) - ((mn << FRAC_BITS) / mx);
      end
      return 9 * h + 3 * s + v;
    endfunction

    function void note_pixel(logic [23:0] pixel, bit last);
      frame_result_t res;
      logic [FEAT_W-1:0] feat;
      // Pixels past the limit are dropped, but a frame end still closes.
      if (frame_pixels < MAX_PIXELS) begin
        frame_sum += hsv_term(pixel);
        frame_pixels++;
      end
      if (!last) return;
      feat = FEAT_W'((frame_sum / 64'(frame_pixels)) >> FRAC_BITS);
      res.feature = feat;
      if (seen_frame) begin
        res.change = (feat > last_feature) ? feat - last_feature : last_feature - feat;
        res.key    = (res.change > threshold);
      end else begin
        res.change = '0;
        res.key    = 1'b1;
      end
      pending_frames.push_back(res);
      last_feature = feat;
      seen_frame   = 1'b1;
      frame_sum    = 0;
      frame_pixels = 0;
    endfunction

    function void check_result(logic [23:0] data, logic key);
      frame_result_t res;
      if (pending_frames.size() == 0) begin
        $display("%0t: result without a pending frame: feature %0d change %0d key %0b",
                 $time, data[11:0], data[23:12], key);
        mismatches++;
        return;
      end
      res = pending_frames.pop_front();
      if (data[11:0] !== res.feature) begin
        $display("%0t: frame_feature expected %0d actual %0d", $time, res.feature,
                 data[11:0]);
        mismatches++;
      end
      if (data[23:12] !== res.change) begin
        $display("%0t: feature_change expected %0d actual %0d", $time, res.change,
                 data[23:12]);
        mismatches++;
      end
      if (key !== res.key) begin
        $display("%0t: is_key expected %0b actual %0b", $time, res.key, key);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [23:0]       s_tdata = '0;
  logic              s_tlast = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [23:0]       m_tdata;
  logic              m_tuser;
  logic              change_threshold_we = 1'b0;
  logic [FEAT_W-1:0] change_threshold_data = '0;

  keyframe_scoreboard sb = new();

  // Sender and receiver behavior, chosen per phase.
  bit          tx_gaps_on = 1'b1;
  bit          rx_always_ready = 1'b0;
  int unsigned burst_left = 0;
  bit          valid_held = 1'b0;
  logic [23:0] last_frame_pixels[$];

  logic [15:0] stall_bits = 16'hA5C3;
  logic [3:0]  stall_pos = '0;

  hsv_keyframe_detector i_dut (
    .clk                   (clk),
    .rst                   (rst),
    .s_tvalid              (s_tvalid),
    .s_tready              (s_tready),
    .s_tdata               (s_tdata),
    .s_tlast               (s_tlast),
    .m_tvalid              (m_tvalid),
    .m_tready              (m_tready),
    .m_tdata               (m_tdata),
    .m_tuser               (m_tuser),
    .change_threshold_we   (change_threshold_we),
    .change_threshold_data (change_threshold_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The receiver walks through a 16-bit ready pattern and draws a new one
  // each time the pattern wraps. Bit 0 of every pattern is set, so a result
  // never waits longer than one pass through the pattern.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_always_ready) begin
      m_tready <= 1'b1;
    end else begin
      m_tready  <= stall_bits[stall_pos];
      stall_pos <= stall_pos + 4'd1;
      if (stall_pos == 4'd15) stall_bits <= 16'($urandom) | 16'h0001;
    end
  end

  // The values seen here are the ones that stood at the edge.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  // Offers one pixel, {red, green, blue}, and returns once it is accepted.
  // The valid stays high into the next transaction unless a gap ends the burst.
  task automatic send_pixel(input logic [23:0] pixel, input bit last);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata  <= pixel;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_pixel(pixel, last);
    if (tx_gaps_on && burst_left == 0) begin
      // Long gaps now and then, so that the next pixel comes at every point
      // of the divider pass.
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
      s_tvalid  <= 1'b0;
      valid_held = 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(0, 24);
    end else begin
      valid_held = 1'b1;
      if (burst_left != 0) burst_left--;
    end
  endtask

  // Holds the sender back until every frame result has been taken.
  task automatic wait_idle();
    if (valid_held) begin
      s_tvalid  <= 1'b0;
      valid_held = 1'b0;
    end
    while (sb.pending_frames.size() != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [FEAT_W-1:0] value);
    change_threshold_we   <= 1'b1;
    change_threshold_data <= value;
    @(posedge clk);
    change_threshold_we <= 1'b0;
    sb.set_threshold(value);
  endtask

  function automatic logic [7:0] pick_level();
    case ($urandom_range(0, 7))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Random pixel that often hits gray, equal components and full-scale values.
  function automatic logic [23:0] pick_pixel();
    logic [7:0] c0, c1, c2;
    c0 = pick_level();
    c1 = pick_level();
    c2 = pick_level();
    case ($urandom_range(0, 9))
      0:       return {c0, c0, c0};
      1:       return {c0, c1, c1};
      2:       return {c1, c1, c0};
      default: return {c2, c1, c0};
    endcase
  endfunction

  // Random frames under one threshold, until about the given pixel count.
  task automatic run_phase(input int items, input logic [FEAT_W-1:0] thresh,
                           input bit gaps, input bit rx_ready);
    logic [23:0] frame_pixels[$];
    int sent;
    int size;
    int k;
    write_threshold(thresh);
    tx_gaps_on      = gaps;
    rx_always_ready = rx_ready;
    sent = 0;
    while (sent < items) begin
      frame_pixels.delete();
      if (last_frame_pixels.size() != 0 && $urandom_range(0, 3) == 0) begin
        // Repeat the previous frame to get a small or zero change.
        frame_pixels = last_frame_pixels;
        if ($urandom_range(0, 1) == 1) begin
          k = $urandom_range(0, frame_pixels.size() - 1);
          frame_pixels[k] = frame_pixels[k] ^ (24'd1 << $urandom_range(0, 23));
        end
      end else begin
        size = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        for (k = 0; k < size; k++) frame_pixels.push_back(pick_pixel());
      end
      for (k = 0; k < frame_pixels.size(); k++)
        send_pixel(frame_pixels[k], k == frame_pixels.size() - 1);
      last_frame_pixels = frame_pixels;
      sent += frame_pixels.size();
    end
    wait_idle();
  endtask

  initial begin
    logic [23:0] mixed_frame[7];
    int k;
    // Both hue branches, equal components, gray and the smallest nonzero max.
    mixed_frame = '{24'hC86464, 24'h3232C8, 24'hFF00FF, 24'hFFFF00, 24'h808080,
                    24'h000001, 24'h010000};

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed frames under the reset threshold. The first frame is a key
    // frame with no change; the repeated mixed frame has a change of zero.
    send_pixel(24'h000000, 1'b1);
    send_pixel(24'hFFFFFF, 1'b1);
    send_pixel(24'hFF0000, 1'b1);
    send_pixel(24'h00FF00, 1'b1);
    send_pixel(24'h0000FF, 1'b1);
    for (k = 0; k < 7; k++) send_pixel(mixed_frame[k], k == 6);
    for (k = 0; k < 7; k++) send_pixel(mixed_frame[k], k == 6);
    send_pixel(24'h7F01FE, 1'b1);
    wait_idle();

    run_phase(180, 12'd0, 1'b1, 1'b0);
    run_phase(180, 12'hFFF, 1'b0, 1'b1);
    run_phase(180, 12'd3244, 1'b1, 1'b1);
    run_phase(180, 12'($urandom_range(1, 60)), 1'b1, 1'b0);
    run_phase(180, 12'($urandom_range(0, 4095)), 1'b0, 1'b0);
    run_phase(180, 12'($urandom_range(60, 600)), 1'b1, 1'b0);

    if (sb.mismatches == 0 && sb.pending_frames.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Even with the longest gaps and stalls a run ends before this bound.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule
